// ===== rtl/cshtc_pkg.sv =====
// Shared types and codes for the chained scatter hash table core.
// No dependencies; imported by every module of the block.
package cshtc_pkg;

    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 16;

    // Action codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_FIND   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]            action;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]            status;
        logic [VALUE_BITS-1:0] found_value;
    } t_out;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_HOME, S_LOC, S_DISP,
        S_FREE_ISS, S_FREE_CHK, S_OMH, S_EVW, S_EV_M,
        S_EV_OM, S_EV_OM2, S_NOEV_F, S_NOEV_M, S_DP,
        S_DNX, S_REL, S_RESP
    } t_state;

endpackage

// ===== rtl/chained_scatter_hash_table_core.sv =====
// Top level of the chained scatter hash table: sequencer over the slot memory.
// Depends on cshtc_pkg, cshtc_mod, cshtc_mem.
//
//  channel | direction | handshake                | payload
//  in      | input     | i_in_valid / o_in_ready  | i_in  (action, key, value)
//  out     | output    | o_out_valid / i_out_ready| o_out (status, found_value)
//
// One item at a time: o_in_ready is high only in the idle state. Each item gets its main slot
// and walks its chain slot by slot; a delete then writes one or two slots. An insert that needs
// a free slot also scans down for one, and walks the occupant's chain when the occupant is moved
// out; a full table ends the scan with a full status. The main-slot unit uses a reciprocal
// multiply when SLOTS is not a power of two.
// After reset the slot memory is cleared with o_in_ready low.
// The result register lets the next item be taken while a result waits.
module chained_scatter_hash_table_core #(
    parameter int SLOTS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  cshtc_pkg::t_in  i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output cshtc_pkg::t_out o_out
);
    import cshtc_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int LW = IW + 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int W  = 1 + LW + KEY_BITS + VALUE_BITS;
    localparam logic [LW-1:0] NULL_LINK = {LW{1'b1}};

    typedef struct packed {
        logic                  used;
        logic [LW-1:0]         link;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_slot;

    t_state r_state, n_state;
    logic [1:0]            r_act, n_act;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [IW-1:0]         r_home, n_home;
    logic [IW-1:0]         r_cur, n_cur;
    logic [IW-1:0]         r_prev, n_prev;
    logic                  r_prev_ok, n_prev_ok;
    logic                  r_hit, n_hit;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [CW-1:0]         r_fp, n_fp;
    logic [IW-1:0]         r_f, n_f;
    logic [IW-1:0]         r_om, n_om;
    logic [IW-1:0]         r_rel, n_rel;
    t_slot                 r_mw, n_mw;
    t_slot                 r_hitw, n_hitw;
    t_slot                 r_omw, n_omw;
    logic [1:0]            r_status, n_status;
    logic [VALUE_BITS-1:0] r_got, n_got;
    logic                  r_ov, n_ov;
    t_out                  r_out, n_out;

    logic                mod_start, mod_done;
    logic [KEY_BITS-1:0] mod_key;
    logic [IW-1:0]       mod_home;

    logic          mem_we, clr_busy;
    logic [IW-1:0] mem_waddr, mem_raddr;
    t_slot         mem_wdata, rd, clr_word;
    logic [W-1:0]  mem_rdata;

    logic [CW-1:0] w_cnt1, w_fpm1, w_rel1;

    assign clr_word = '{used: 1'b0, link: NULL_LINK, key: '0, value: '0};
    assign rd       = mem_rdata;
    assign w_cnt1   = r_cnt + CW'(1);
    assign w_fpm1   = r_fp - CW'(1);
    assign w_rel1   = CW'(r_rel) + CW'(1);

    cshtc_mod #(.SLOTS(SLOTS)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_key   (mod_key),
        .o_done  (mod_done),
        .o_home  (mod_home)
    );

    cshtc_mem #(.SLOTS(SLOTS), .W(W)) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (mem_we),
        .i_waddr    (mem_waddr),
        .i_wdata    (mem_wdata),
        .i_raddr    (mem_raddr),
        .i_clr_word (clr_word),
        .o_rdata    (mem_rdata),
        .o_clr_busy (clr_busy)
    );

    // sequencer: next state, memory ports, result
    always_comb begin
        n_state = r_state;   n_act = r_act;     n_key = r_key;   n_val = r_val;
        n_home = r_home;     n_cur = r_cur;     n_prev = r_prev; n_prev_ok = r_prev_ok;
        n_hit = r_hit;       n_cnt = r_cnt;     n_fp = r_fp;     n_f = r_f;
        n_om = r_om;         n_rel = r_rel;     n_mw = r_mw;     n_hitw = r_hitw;
        n_omw = r_omw;       n_status = r_status; n_got = r_got;
        n_ov = r_ov && !i_out_ready;
        n_out = r_out;
        mod_start = 1'b0;
        mod_key   = r_key;
        mem_we    = 1'b0;
        mem_waddr = r_cur;
        mem_wdata = clr_word;
        mem_raddr = r_cur;

        unique case (r_state)
            S_CLR: begin
                if (!clr_busy) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act = i_in.action;
                    n_key = i_in.key;
                    n_val = i_in.value;
                    n_status = ST_MISSING;
                    n_got = '0;
                    mod_start = 1'b1;
                    mod_key = i_in.key;
                    n_state = S_HOME;
                end
            end
            S_HOME: begin
                if (mod_done) begin
                    n_home = mod_home;
                    n_cur = mod_home;
                    n_cnt = '0;
                    n_prev_ok = 1'b0;
                    mem_raddr = mod_home;
                    n_state = S_LOC;
                end
            end
            // chain walk, one slot a cycle
            S_LOC: begin
                if (r_cnt == '0) n_mw = rd;
                if (rd.used && rd.key == r_key) begin
                    n_hit = 1'b1;
                    n_hitw = rd;
                    n_state = S_DISP;
                end else if (w_cnt1 < CW'(SLOTS) && rd.link < LW'(SLOTS)) begin
                    n_cnt = w_cnt1;
                    n_prev = r_cur;
                    n_prev_ok = 1'b1;
                    n_cur = rd.link[IW-1:0];
                    mem_raddr = rd.link[IW-1:0];
                end else begin
                    n_hit = 1'b0;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_RESP;
                if (r_hit) begin
                    case (r_act)
                        ACT_INSERT: begin
                            mem_we = 1'b1;
                            mem_waddr = r_cur;
                            mem_wdata = r_hitw;
                            mem_wdata.value = r_val;
                            n_status = ST_OK;
                        end
                        ACT_DELETE: begin
                            n_got = r_hitw.value;
                            if (r_cur != r_home && r_prev_ok) begin
                                mem_raddr = r_prev;
                                n_state = S_DP;
                            end else if (r_hitw.link < LW'(SLOTS)) begin
                                mem_raddr = r_hitw.link[IW-1:0];
                                n_rel = r_hitw.link[IW-1:0];
                                n_state = S_DNX;
                            end else begin
                                n_rel = r_cur;
                                n_state = S_REL;
                            end
                        end
                        ACT_FIND: begin
                            n_got = r_hitw.value;
                            n_status = ST_OK;
                        end
                        default: n_status = ST_MISSING;
                    endcase
                end else if (r_act == ACT_INSERT) begin
                    if (!r_mw.used) begin
                        mem_we = 1'b1;
                        mem_waddr = r_home;
                        mem_wdata = '{used: 1'b1, link: r_mw.link, key: r_key, value: r_val};
                        n_status = ST_OK;
                    end else begin
                        n_state = S_FREE_ISS;
                    end
                end
            end
            // free-slot scan down from the pointer
            S_FREE_ISS: begin
                if (r_fp == '0) begin
                    n_status = ST_FULL;
                    n_state = S_RESP;
                end else begin
                    mem_raddr = w_fpm1[IW-1:0];
                    n_f = w_fpm1[IW-1:0];
                    n_fp = w_fpm1;
                    n_state = S_FREE_CHK;
                end
            end
            S_FREE_CHK: begin
                if (!rd.used) begin
                    mod_start = 1'b1;
                    mod_key = r_mw.key;
                    n_state = S_OMH;
                end else if (r_fp == '0) begin
                    n_status = ST_FULL;
                    n_state = S_RESP;
                end else begin
                    mem_raddr = w_fpm1[IW-1:0];
                    n_f = w_fpm1[IW-1:0];
                    n_fp = w_fpm1;
                end
            end
            S_OMH: begin
                if (mod_done) begin
                    n_om = mod_home;
                    if (mod_home != r_home) begin
                        n_cur = mod_home;
                        n_cnt = '0;
                        mem_raddr = mod_home;
                        n_state = S_EVW;
                    end else begin
                        n_state = S_NOEV_F;
                    end
                end
            end
            // colliding occupant is at home: chain the new key after it
            S_NOEV_F: begin
                mem_we = 1'b1;
                mem_waddr = r_f;
                mem_wdata = '{used: 1'b1, link: r_mw.link, key: r_key, value: r_val};
                n_state = S_NOEV_M;
            end
            S_NOEV_M: begin
                mem_we = 1'b1;
                mem_waddr = r_home;
                mem_wdata = r_mw;
                mem_wdata.link = {1'b0, r_f};
                n_status = ST_OK;
                n_state = S_RESP;
            end
            // find the predecessor of the main slot in the occupant's chain
            S_EVW: begin
                if (rd.link == {1'b0, r_home}) begin
                    mem_we = 1'b1;
                    mem_waddr = r_cur;
                    mem_wdata = rd;
                    mem_wdata.link = r_mw.link;
                    n_state = S_EV_M;
                end else if (w_cnt1 < CW'(SLOTS) && rd.link < LW'(SLOTS)) begin
                    n_cnt = w_cnt1;
                    n_cur = rd.link[IW-1:0];
                    mem_raddr = rd.link[IW-1:0];
                end else begin
                    n_state = S_EV_M;
                end
            end
            S_EV_M: begin
                mem_we = 1'b1;
                mem_waddr = r_home;
                mem_wdata = '{used: 1'b1, link: NULL_LINK, key: r_key, value: r_val};
                mem_raddr = r_om;
                n_state = S_EV_OM;
            end
            S_EV_OM: begin
                mem_we = 1'b1;
                mem_wdata = '{used: 1'b1, link: rd.link, key: r_mw.key, value: r_mw.value};
                if (!rd.used) begin
                    mem_waddr = r_om;
                    n_status = ST_OK;
                    n_state = S_RESP;
                end else begin
                    mem_waddr = r_f;
                    n_omw = rd;
                    n_state = S_EV_OM2;
                end
            end
            S_EV_OM2: begin
                mem_we = 1'b1;
                mem_waddr = r_om;
                mem_wdata = r_omw;
                mem_wdata.link = {1'b0, r_f};
                n_status = ST_OK;
                n_state = S_RESP;
            end
            // delete: unlink from predecessor
            S_DP: begin
                mem_we = 1'b1;
                mem_waddr = r_prev;
                mem_wdata = rd;
                mem_wdata.link = r_hitw.link;
                n_rel = r_cur;
                n_state = S_REL;
            end
            // delete: pull successor into this slot
            S_DNX: begin
                mem_we = 1'b1;
                mem_waddr = r_cur;
                mem_wdata = '{used: 1'b1, link: rd.link, key: rd.key, value: rd.value};
                n_state = S_REL;
            end
            S_REL: begin
                mem_we = 1'b1;
                mem_waddr = r_rel;
                mem_wdata = clr_word;
                if (w_rel1 > r_fp) n_fp = w_rel1;
                n_status = ST_OK;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_ov || i_out_ready) begin
                    n_ov = 1'b1;
                    n_out = '{status: r_status, found_value: r_got};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_fp    <= CW'(SLOTS);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fp    <= n_fp;
            r_ov    <= n_ov;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_act <= n_act;   r_key <= n_key;   r_val <= n_val;   r_home <= n_home;
        r_cur <= n_cur;   r_prev <= n_prev; r_prev_ok <= n_prev_ok;
        r_hit <= n_hit;   r_cnt <= n_cnt;   r_f <= n_f;       r_om <= n_om;
        r_rel <= n_rel;   r_mw <= n_mw;     r_hitw <= n_hitw; r_omw <= n_omw;
        r_status <= n_status; r_got <= n_got; r_out <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    // checks
    a_fp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fp <= CW'(SLOTS)) else $error("free pointer out of range");
    a_no_wr_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !mem_we) else $error("write during clear pass");
    a_rdy_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !o_in_ready) else $error("input ready during clear pass");
    a_full_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_status == ST_FULL) |-> (r_act == ACT_INSERT))
        else $error("full status on non-insert");

endmodule

// ===== rtl/cshtc_mod.sv =====
// Main-slot unit: key modulo SLOTS.
// Depends on cshtc_pkg. A power-of-two SLOTS takes the low key bits, else a reciprocal multiply.
module cshtc_mod #(
    parameter int SLOTS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [cshtc_pkg::KEY_BITS-1:0] i_key,
    output logic                         o_done,
    output logic [$clog2(SLOTS)-1:0]     o_home
);
    import cshtc_pkg::*;

    localparam int IW   = $clog2(SLOTS);
    localparam bit POW2 = ((SLOTS & (SLOTS - 1)) == 0);

    generate
        if (POW2) begin : g_pow2
            logic          r_done;
            logic [IW-1:0] r_home;

            // low key bits are the slot
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
                if (i_start) r_home <= i_key[IW-1:0];
            end
            assign o_done = r_done;
            assign o_home = r_home;
        end else begin : g_recip
            // reciprocal scaled to fit KEY_BITS bits; quotient estimate is exact or one low
            localparam int                  SH         = KEY_BITS + IW - 1;
            localparam logic [63:0]         RECIP_FULL = (64'd1 << SH) / 64'(SLOTS);
            localparam logic [KEY_BITS-1:0] RECIP      = RECIP_FULL[KEY_BITS-1:0];

            logic                  r_v1, r_v2;
            logic [2*KEY_BITS-1:0] r_prod;
            logic [IW:0]           r_klo;
            logic [IW:0]           r_rem;
            logic [IW:0]           w_qd;
            logic [IW:0]           w_fix;

            // low bits of quotient times SLOTS; remainder is below 2*SLOTS
            assign w_qd  = (IW+1)'(r_prod[SH +: IW+1] * (IW+1)'(SLOTS));
            assign w_fix = (r_rem >= (IW+1)'(SLOTS)) ? (r_rem - (IW+1)'(SLOTS)) : r_rem;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v1 <= 1'b0;
                    r_v2 <= 1'b0;
                end else begin
                    r_v1 <= i_start;
                    r_v2 <= r_v1;
                end
                if (i_start) begin
                    r_prod <= (2*KEY_BITS)'(i_key) * (2*KEY_BITS)'(RECIP);
                    r_klo  <= i_key[IW:0];
                end
                r_rem <= r_klo - w_qd;
            end
            assign o_done = r_v2;
            assign o_home = w_fix[IW-1:0];
        end
    endgenerate

endmodule

// ===== rtl/cshtc_mem.sv =====
// Slot memory: one write port, one registered read port, clearing pass after reset.
// Depends on cshtc_pkg only by convention; word layout is owned by the top level.
module cshtc_mem #(
    parameter int SLOTS = 64,
    parameter int W     = 56
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(SLOTS)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(SLOTS)-1:0] i_raddr,
    input  logic [W-1:0]             i_clr_word,
    output logic [W-1:0]             o_rdata,
    output logic                     o_clr_busy
);
    import cshtc_pkg::*;

    localparam int IW = $clog2(SLOTS);

    logic [W-1:0]  r_mem [SLOTS];
    logic [W-1:0]  r_rdata;
    logic          r_busy;
    logic [IW-1:0] r_idx;

    // clear sweep, one slot a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy) begin
            r_idx <= r_idx + IW'(1);
            if (r_idx == IW'(SLOTS - 1)) r_busy <= 1'b0;
        end
    end

    // array write and registered read
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_idx] <= i_clr_word;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata    = r_rdata;
    assign o_clr_busy = r_busy;

endmodule

// ===== verif/tb_chained_scatter_hash_table_core.sv =====
// Testbench for chained_scatter_hash_table_core: directed and random insert, delete and
// find traffic checked against a behavioral hash table model. Depends on cshtc_pkg.
module tb_chained_scatter_hash_table_core;
    import cshtc_pkg::*;

    localparam int NSLOT = 64;
    localparam int NIL   = -1;
    localparam logic [1:0] ACT_UNDEF = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out;

    chained_scatter_hash_table_core #(.SLOTS(NSLOT)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    // Model table state
    logic [31:0] tbl_key [NSLOT];
    logic [15:0] tbl_val [NSLOT];
    bit          tbl_used[NSLOT];
    int          tbl_link[NSLOT];
    int          scan_ptr;

    t_out pending_results[$];
    int   mismatch_cnt;
    int   error_cnt;
    bit   quiet_out;
    bit   quiet_in;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic int home_slot(logic [31:0] k);
        return int'(k % NSLOT);
    endfunction

    // Walk the chain from the main slot; returns slot or NIL, prior link in prv
    function automatic int chain_find(logic [31:0] k, output int prv);
        int cur;
        int p;
        cur = home_slot(k);
        p   = NIL;
        prv = NIL;
        for (int n = 0; n < NSLOT && cur >= 0; n++) begin
            if (tbl_used[cur] && tbl_key[cur] == k) begin
                prv = p;
                return cur;
            end
            p   = cur;
            cur = tbl_link[cur];
        end
        return NIL;
    endfunction

    function automatic int grab_free_slot();
        int idx;
        while (scan_ptr >= 0) begin
            idx = scan_ptr;
            scan_ptr--;
            if (!tbl_used[idx]) return idx;
        end
        return NIL;
    endfunction

    function automatic void free_slot(int idx);
        tbl_used[idx] = 0;
        tbl_link[idx] = NIL;
        if (idx > scan_ptr) scan_ptr = idx;
    endfunction

    function automatic void put_slot(int idx, logic [31:0] k, logic [15:0] v);
        tbl_key[idx]  = k;
        tbl_val[idx]  = v;
        tbl_used[idx] = 1;
    endfunction

    function automatic logic [1:0] model_insert(logic [31:0] k, logic [15:0] v);
        int prv, hit, m, f, om, p;
        logic [31:0] ek;
        logic [15:0] ev;
        hit = chain_find(k, prv);
        if (hit != NIL) begin
            tbl_val[hit] = v;
            return ST_OK;
        end
        m = home_slot(k);
        if (!tbl_used[m]) begin
            put_slot(m, k, v);
            return ST_OK;
        end
        f = grab_free_slot();
        if (f == NIL) return ST_FULL;
        om = home_slot(tbl_key[m]);
        if (om != m) begin
            // Occupant is a guest here: unlink it and move it out
            ek = tbl_key[m];
            ev = tbl_val[m];
            p  = om;
            for (int n = 0; n < NSLOT && p >= 0; n++) begin
                if (tbl_link[p] == m) begin
                    tbl_link[p] = tbl_link[m];
                    break;
                end
                p = tbl_link[p];
            end
            put_slot(m, k, v);
            tbl_link[m] = NIL;
            if (!tbl_used[om]) begin
                put_slot(om, ek, ev);
            end else begin
                put_slot(f, ek, ev);
                tbl_link[f]  = tbl_link[om];
                tbl_link[om] = f;
            end
        end else begin
            put_slot(f, k, v);
            tbl_link[f] = tbl_link[m];
            tbl_link[m] = f;
        end
        return ST_OK;
    endfunction

    function automatic t_out predict_table_op(t_in req);
        t_out r;
        int prv, cur, nx;
        r.status      = ST_MISSING;
        r.found_value = '0;
        case (req.action)
            ACT_INSERT: begin
                r.status = model_insert(req.key, req.value);
            end
            ACT_DELETE: begin
                cur = chain_find(req.key, prv);
                if (cur != NIL) begin
                    r.status      = ST_OK;
                    r.found_value = tbl_val[cur];
                    if (cur != home_slot(req.key) && prv >= 0) begin
                        tbl_link[prv] = tbl_link[cur];
                        free_slot(cur);
                    end else if (tbl_link[cur] >= 0) begin
                        // pull the successor into this slot
                        nx = tbl_link[cur];
                        tbl_key[cur]  = tbl_key[nx];
                        tbl_val[cur]  = tbl_val[nx];
                        tbl_link[cur] = tbl_link[nx];
                        free_slot(nx);
                    end else begin
                        free_slot(cur);
                    end
                end
            end
            ACT_FIND: begin
                cur = chain_find(req.key, prv);
                if (cur != NIL) begin
                    r.status      = ST_OK;
                    r.found_value = tbl_val[cur];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Send one transfer, sometimes after a random idle gap; valid stays high between
    // back-to-back transfers
    task automatic send_op(logic [1:0] act, logic [31:0] k, logic [15:0] v);
        t_in req;
        if (!quiet_in && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        req.action = act;
        req.key    = k;
        req.value  = v;
        i_in       <= req;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(predict_table_op(req));
        @(negedge i_clk);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                error_cnt++;
                if (mismatch_cnt < 10) $display("unexpected result %p", o_out);
                mismatch_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (o_out.status !== want.status || o_out.found_value !== want.found_value) begin
                    error_cnt++;
                    if (mismatch_cnt < 10)
                        $display("mismatch: exp status %0d value %h, got status %0d value %h",
                                 want.status, want.found_value, o_out.status,
                                 o_out.found_value);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Receiver stall bursts
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (quiet_out || $urandom_range(0, 4) != 0) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic test_directed();
        send_op(ACT_FIND, 32'h0, 16'h0);
        send_op(ACT_DELETE, 32'hFFFF_FFFF, 16'h0);
        send_op(ACT_INSERT, 32'h0, 16'hFFFF);
        send_op(ACT_INSERT, 32'hFFFF_FFFF, 16'h0);
        send_op(ACT_INSERT, 32'h0, 16'h1234);      // replace existing value
        send_op(ACT_FIND, 32'h0, 16'hFFFF);
        send_op(ACT_INSERT, 32'h40, 16'hAAAA);     // collide on slot 0
        send_op(ACT_INSERT, 32'h80, 16'h5555);
        send_op(ACT_INSERT, 32'h3E, 16'h0001);     // lands where a guest may sit
        send_op(ACT_FIND, 32'h80, 16'h0);
        send_op(ACT_DELETE, 32'h0, 16'h0);         // successor pulled into main slot
        send_op(ACT_DELETE, 32'h80, 16'h0);
        send_op(ACT_FIND, 32'h40, 16'h0);
        send_op(ACT_UNDEF, 32'h40, 16'hFFFF);      // undefined action
        send_op(ACT_DELETE, 32'h40, 16'h0);
        send_op(ACT_DELETE, 32'h3F, 16'h0);
        send_op(ACT_DELETE, 32'hFFFF_FFFF, 16'h0);
        send_op(ACT_DELETE, 32'h3E, 16'h0);
    endtask

    // Fill to overflow, then drain
    task automatic test_full_table();
        for (int i = 0; i < NSLOT + 4; i++)
            send_op(ACT_INSERT, {24'($urandom_range(0, 255)), 2'b0, 6'(i * 7)},
                    16'($urandom));
        for (int i = 0; i < 6; i++)
            send_op(ACT_INSERT, $urandom, 16'($urandom));
        for (int i = 0; i < NSLOT; i++)
            if (tbl_used[i]) send_op(ACT_DELETE, tbl_key[i], 16'h0);
    endtask

    // Random traffic from a small key pool so chains and hits are common
    task automatic test_random(int count);
        logic [31:0] pool[32];
        logic [31:0] k;
        int sel;
        for (int i = 0; i < 32; i++)
            pool[i] = {$urandom_range(0, 7) == 0 ? 26'($urandom) : 26'($urandom_range(0, 5)),
                       6'($urandom_range(0, 15))};
        for (int i = 0; i < count; i++) begin
            k = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, 31)];
            sel = $urandom_range(0, 19);
            send_op(sel < 9 ? ACT_INSERT : sel < 14 ? ACT_DELETE : sel < 19 ? ACT_FIND
                    : ACT_UNDEF, k, 16'($urandom));
        end
    endtask

    initial begin
        int wait_cnt;
        mismatch_cnt = 0;
        error_cnt    = 0;
        quiet_out    = 0;
        quiet_in     = 0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in         = '0;
        for (int i = 0; i < NSLOT; i++) begin
            tbl_key[i]  = '0;
            tbl_val[i]  = '0;
            tbl_used[i] = 0;
            tbl_link[i] = NIL;
        end
        scan_ptr = NSLOT - 1;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_full_table();
        test_random(1500);
        test_full_table();
        quiet_in  = 1;
        quiet_out = 1;
        test_random(200);
        i_in_valid <= 1'b0;

        wait_cnt = 0;
        while (pending_results.size() != 0 && wait_cnt < 10000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (200) @(posedge i_clk);
        if (error_cnt == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
